[rtl/fpd_pkg.sv]
// Shared types and constants for the fixed-point divider.
// No dependencies; imported by every other file of the block.
`default_nettype none

package fpd_pkg;

  localparam int FPD_FRAC_BITS = 16;
  localparam int FPD_WORD_BITS = 32;

  // result status codes
  typedef enum logic [1:0] {
    FPD_STATUS_OK   = 2'd0,
    FPD_STATUS_OVF  = 2'd1,
    FPD_STATUS_DIV0 = 2'd2
  } fpd_status_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;   // capture operands, start a new division
    logic step;   // one restoring iteration
    logic store;  // write the finished word into the output register
  } fpd_cmd_t;

endpackage

`default_nettype wire

[rtl/fpd_ctrl.sv]
// Sequencer for the fixed-point divider: handshakes, step counter, commands.
// Depends on fpd_pkg.
`default_nettype none

module fpd_ctrl #(
  parameter int STEPS = fpd_pkg::FPD_WORD_BITS + fpd_pkg::FPD_FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output fpd_pkg::fpd_cmd_t cmd
);
  import fpd_pkg::*;

  localparam int CNT_W = $clog2(STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic             out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.load  = in_valid && in_ready;
    cmd.step  = (state == ST_RUN);
    cmd.store = (state == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.load) begin
            state <= ST_RUN;
            count <= '0;
          end
        end
        ST_RUN: begin
          if (count == CNT_W'(STEPS - 1)) begin
            state <= ST_DONE;
          end else begin
            count <= count + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (cmd.store) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/fpd_dp.sv]
// Datapath of the fixed-point divider: operand magnitudes, restoring
// shift/subtract loop, saturation, sign and output register. Depends on fpd_pkg.
`default_nettype none

module fpd_dp #(
  parameter int WORD_BITS = fpd_pkg::FPD_WORD_BITS,
  parameter int FRAC_BITS = fpd_pkg::FPD_FRAC_BITS
) (
  input  logic                        clk,
  input  fpd_pkg::fpd_cmd_t           cmd,
  input  logic signed [WORD_BITS-1:0] dividend,
  input  logic signed [WORD_BITS-1:0] divisor,
  output logic signed [WORD_BITS-1:0] quotient,
  output logic [1:0]                  status
);
  import fpd_pkg::*;

  localparam int QW = WORD_BITS + FRAC_BITS;
  localparam logic [QW-1:0] LIM_POS = (QW'(1) << (WORD_BITS - 1)) - QW'(1);
  localparam logic [QW-1:0] LIM_NEG = QW'(1) << (WORD_BITS - 1);
  localparam logic [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // working registers
  logic [WORD_BITS-1:0] den_mag;
  logic [WORD_BITS-1:0] rem;
  logic [QW-1:0]        acc;      // shifted dividend in, quotient bits out
  logic                 neg;
  logic                 num_neg;
  logic                 div_zero;

  logic [WORD_BITS-1:0] dividend_mag;
  logic [WORD_BITS-1:0] divisor_mag;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS:0]   diff;
  logic                 fits;
  logic [WORD_BITS-1:0] rem_next;

  logic [QW-1:0]        lim;
  logic                 over;
  logic [WORD_BITS-1:0] q_sat;
  logic [WORD_BITS-1:0] q_signed;
  logic [WORD_BITS-1:0] quotient_next;
  fpd_status_t          status_next;

  assign dividend_mag = dividend[WORD_BITS-1] ? (~dividend + 1'b1) : dividend;
  assign divisor_mag  = divisor[WORD_BITS-1]  ? (~divisor + 1'b1)  : divisor;

  // one restoring step: bring down the next dividend bit, try the subtract
  assign trial    = {rem, acc[QW-1]};
  assign fits     = trial >= {1'b0, den_mag};
  assign diff     = trial - {1'b0, den_mag};
  assign rem_next = fits ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];

  // finish: saturate magnitude to signed limit, apply sign; zero divisor: limit
  always_comb begin
    lim      = neg ? LIM_NEG : LIM_POS;
    over     = acc > lim;
    q_sat    = over ? lim[WORD_BITS-1:0] : acc[WORD_BITS-1:0];
    q_signed = neg ? (~q_sat + 1'b1) : q_sat;
    if (div_zero) begin
      quotient_next = num_neg ? W_MIN : W_MAX;
      status_next   = FPD_STATUS_DIV0;
    end else if (over) begin
      quotient_next = q_signed;
      status_next   = FPD_STATUS_OVF;
    end else begin
      quotient_next = q_signed;
      status_next   = FPD_STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      den_mag  <= divisor_mag;
      rem      <= '0;
      acc      <= {dividend_mag, {FRAC_BITS{1'b0}}};
      num_neg  <= dividend[WORD_BITS-1];
      neg      <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
      div_zero <= (divisor == '0);
    end else if (cmd.step) begin
      rem <= rem_next;
      acc <= {acc[QW-2:0], fits};
    end
    if (cmd.store) begin
      quotient <= quotient_next;
      status   <= status_next;
    end
  end

endmodule

`default_nettype wire

[rtl/fixed_point_divider_core.sv]
// Top level of the signed fixed-point divider: sequencer plus datapath.
// Depends on fpd_pkg, fpd_ctrl and fpd_dp.
`default_nettype none

//  channel | signals                          | word
//  --------+----------------------------------+---------------------------------
//  in      | in_valid, in_ready               | dividend, divisor (signed Q.FRAC)
//  out     | out_valid, out_ready             | quotient (signed Q.FRAC), status
//
//  A word takes WORD_BITS+FRAC_BITS restoring steps on one shared subtractor,
//  one quotient bit per cycle (48 at the defaults), then a finish step that
//  saturates, signs and stores it. The next word is taken only after the
//  finished word is stored; no new word is accepted while one is divided.
//  The output register holds a finished word while the next one is divided;
//  a stalled out channel only delays the finish step.
//  rst is synchronous and clears the sequencer and out_valid.

module fixed_point_divider_core #(
  parameter int FRAC_BITS = fpd_pkg::FPD_FRAC_BITS,
  parameter int WORD_BITS = fpd_pkg::FPD_WORD_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [WORD_BITS-1:0] dividend,
  input  logic signed [WORD_BITS-1:0] divisor,
  // output channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [WORD_BITS-1:0] quotient,
  output logic [1:0]                  status
);
  import fpd_pkg::*;

  // one iteration per bit of the shifted dividend
  localparam int STEPS = WORD_BITS + FRAC_BITS;

  fpd_cmd_t cmd;

  fpd_ctrl #(
    .STEPS(STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  fpd_dp #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .dividend(dividend),
    .divisor (divisor),
    .quotient(quotient),
    .status  (status)
  );

endmodule

`default_nettype wire

[rtl/fpd_chk.sv]
// Port-level checks for fixed_point_divider_core, bound to the top level.
// Depends on fpd_pkg.
`default_nettype none

module fpd_chk #(
  parameter int WORD_BITS = fpd_pkg::FPD_WORD_BITS
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [WORD_BITS-1:0] quotient,
  input logic [1:0]                  status
);
  import fpd_pkg::*;

  localparam logic [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // no result word survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quotient) && $stable(status))
    else $error("stalled result changed");

  // saturation and divide-by-zero give a range limit
  a_ovf_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == FPD_STATUS_OVF |-> quotient == W_MAX || quotient == W_MIN)
    else $error("overflow result not saturated");

  a_div0_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == FPD_STATUS_DIV0 |-> quotient == W_MAX || quotient == W_MIN)
    else $error("divide-by-zero result not saturated");

  // a division never overlaps acceptance: no accept while busy back to back
  a_no_double_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while dividing");

endmodule

bind fixed_point_divider_core fpd_chk #(
  .WORD_BITS(WORD_BITS)
) u_fpd_chk (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .quotient (quotient),
  .status   (status)
);

`default_nettype wire
